>>> hdl/wdts_pkg.sv
`default_nettype none
package wdts_pkg;

  localparam int unsigned SAMPLE_W    = 21;
  localparam int unsigned WL_W        = 7;
  localparam logic [WL_W-1:0] WL_RESET = 7'd7;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned MEAN_W      = 21;
  localparam int unsigned PCT_W       = 21;
  localparam int unsigned SPREAD_W    = 20;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned PCT_SCALE   = 100;
  localparam int unsigned ABS_DIFF_W  = 21;
  localparam int unsigned SCALED_W    = 28;
  localparam int unsigned PCT_NUM_W   = 30;
  localparam logic [PCT_W-1:0]    PCT_LIMIT  = 21'd1000000;
  localparam logic [SPREAD_W-1:0] SPREAD_MAX = 20'hFFFFF;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = 16'hFFFF;

  typedef struct packed {
    logic accept;
    logic scan;
    logic math1;
    logic math2;
    logic div_pct;
    logic div_sd;
    logic finish;
  } wdts_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic busy;
  } wdts_stat_t;

endpackage
`default_nettype wire

>>> hdl/wdts_ram.sv
`default_nettype none
module wdts_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 65
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> hdl/wdts_div.sv
`default_nettype none
module wdts_div #(
  parameter int unsigned NW = 30
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [NW-1:0] den_i,
  output logic               busy_o,
  output logic    [NW-1:0]   quo_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW:0]   trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[NW-1]};
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
      cnt_d = CW'(NW);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = NW'(trial - {1'b0, den_q});
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[NW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

>>> hdl/wdts_sqrt.sv
`default_nettype none
module wdts_sqrt #(
  parameter int unsigned RW = 28
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [2*RW-1:0] rad_i,
  output logic                 busy_o,
  output logic      [RW-1:0]   root_o
);

  localparam int unsigned CW = $clog2(RW + 1);

  logic [2*RW-1:0] rad_q, rad_d;
  logic [RW+1:0]   rem_q, rem_d;
  logic [RW-1:0]   root_q, root_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [RW+1:0]   trial_rem, trial_sub;

  // digit-by-digit root, two radicand bits per cycle
  always_comb begin
    rad_d     = rad_q;
    rem_d     = rem_q;
    root_d    = root_q;
    cnt_d     = cnt_q;
    trial_rem = {rem_q[RW-1:0], rad_q[2*RW-1:2*RW-2]};
    trial_sub = {root_q, 2'b01};
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CW'(RW);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rad_d = {rad_q[2*RW-3:0], 2'b00};
      if (trial_rem >= trial_sub) begin
        rem_d  = trial_rem - trial_sub;
        root_d = {root_q[RW-2:0], 1'b1};
      end else begin
        rem_d  = trial_rem;
        root_d = {root_q[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

endmodule
`default_nettype wire

>>> hdl/wdts_ctrl.sv
`default_nettype none
module wdts_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire wdts_pkg::wdts_stat_t stat_i,
  output wdts_pkg::wdts_cmd_t     cmd_o
);
  import wdts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MATH1,
    ST_MATH2,
    ST_WAIT_A,
    ST_WAIT_B,
    ST_WAIT_C,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = ST_MATH1;
        end
      end
      ST_MATH1: begin
        cmd_o.math1 = 1'b1;
        state_d     = ST_MATH2;
      end
      ST_MATH2: begin
        cmd_o.math2 = 1'b1;
        state_d     = ST_WAIT_A;
      end
      ST_WAIT_A: begin
        if (!stat_i.busy) begin
          cmd_o.div_pct = 1'b1;
          state_d       = ST_WAIT_B;
        end
      end
      ST_WAIT_B: begin
        if (!stat_i.busy) begin
          cmd_o.div_sd = 1'b1;
          state_d      = ST_WAIT_C;
        end
      end
      ST_WAIT_C: begin
        if (!stat_i.busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

>>> hdl/wdts_dp.sv
`default_nettype none
module wdts_dp #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [wdts_pkg::WL_W-1:0]             cfg_wdata_i,
  input  wire logic [wdts_pkg::SAMPLE_W-1:0]         sample_i,
  input  wire wdts_pkg::wdts_cmd_t                   cmd_i,
  output wdts_pkg::wdts_stat_t                       stat_o,
  output logic      [wdts_pkg::OUT_TDATA_W-1:0]      out_data_o
);
  import wdts_pkg::*;

  localparam int unsigned DEPTH = MAX_WINDOW + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NB    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned HW    = $clog2(MAX_WINDOW + 2);
  localparam int unsigned LC    = $clog2(MAX_WINDOW);
  localparam int unsigned SW    = SAMPLE_W + LC;
  localparam int unsigned QW    = 2 * SAMPLE_W - 1 + LC;
  localparam int unsigned RSW   = SAMPLE_W + LC;
  localparam int unsigned VW    = QW + NB;
  localparam int unsigned RW    = (VW + 3) / 2;
  localparam int unsigned NW0   = (RSW + 2 > PCT_NUM_W) ? RSW + 2 : PCT_NUM_W;
  localparam int unsigned NW    = (RW > NW0) ? RW : NW0;

  // window length register and item state
  logic [WL_W-1:0] wl_q;
  logic [AW-1:0]   wp_q, rd_idx_q;
  logic [HW-1:0]   held_q;
  logic            last_neg_q;
  logic [COUNT_W-1:0] count_q;
  logic [NB-1:0]   k_q, n_q;
  logic            rv_q, sv_q;

  logic signed [SAMPLE_W-1:0] x_q, prev_q, ref_q;
  logic signed [SW-1:0]       s_q;
  logic [QW-1:0]              sq_q;
  logic [RSW-1:0]             rsum_q;

  logic signed [2*SW-1:0]     ss_q;
  logic [VW-1:0]              nsq_q;
  logic [SCALED_W-1:0]        an_q;
  logic [ABS_DIFF_W-1:0]      ad_q;
  logic                       neg_q, refnz_q;
  logic [NW-1:0]              rise_q, pct_q;
  logic [OUT_TDATA_W-1:0]     out_q;

  logic [NB-1:0]   n_new;
  logic [HW-1:0]   held_new;
  logic [AW-1:0]   wp_prev;
  logic [SAMPLE_W-1:0] ram_rd;
  logic signed [SAMPLE_W-1:0] cur;
  logic signed [2*SAMPLE_W-1:0] sqr;
  logic signed [SAMPLE_W:0]   rise_d;
  logic signed [SAMPLE_W:0]   dif;
  logic [ABS_DIFF_W-1:0]      absdif, absref;
  logic [VW-1:0]              v;

  logic          div_start, sqrt_start, div_busy, sqrt_busy;
  logic [NW-1:0] div_num, div_den, div_quo;
  logic [RW-1:0] root;

  assign n_new = (wl_q == '0) ? NB'(1) :
                 ((32'(wl_q) > MAX_WINDOW) ? NB'(MAX_WINDOW) : NB'(wl_q));
  assign held_new = (32'(held_q) == DEPTH) ? held_q : held_q + 1'b1;
  assign wp_prev  = (wp_q == '0) ? AW'(DEPTH - 1) : wp_q - 1'b1;

  wdts_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rd)
  );

  // element k of the window: current sample, then ring reads going back
  assign cur    = (k_q == '0) ? x_q : $signed(ram_rd);
  assign sqr    = cur * cur;
  assign rise_d = {prev_q[SAMPLE_W-1], prev_q} - {cur[SAMPLE_W-1], cur};

  assign dif    = {x_q[SAMPLE_W-1], x_q} - {ref_q[SAMPLE_W-1], ref_q};
  assign absdif = dif[SAMPLE_W] ? ABS_DIFF_W'(-dif) : ABS_DIFF_W'(dif);
  assign absref = ref_q[SAMPLE_W-1] ? ABS_DIFF_W'(-{ref_q[SAMPLE_W-1], ref_q})
                                    : ABS_DIFF_W'(ref_q);
  // exact v stays below 2^VW, so wrapping arithmetic is fine
  assign v = nsq_q - VW'(ss_q);

  always_comb begin
    div_start  = 1'b0;
    sqrt_start = cmd_i.math2;
    div_num    = NW'({rsum_q, 1'b0}) + NW'(n_q);
    div_den    = NW'({n_q, 1'b0});
    if (cmd_i.math2) begin
      div_start = 1'b1;
    end else if (cmd_i.div_pct) begin
      div_start = 1'b1;
      div_num   = NW'({an_q, 1'b0}) + NW'(ad_q);
      div_den   = NW'({ad_q, 1'b0});
    end else if (cmd_i.div_sd) begin
      div_start = 1'b1;
      div_num   = NW'(root);
      div_den   = NW'(n_q);
    end
  end

  wdts_div #(
    .NW (NW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  wdts_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   ((2*RW)'({v, 2'b00})),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  assign stat_o.scan_last = (k_q == n_q);
  assign stat_o.busy      = div_busy || sqrt_busy;

  // result assembly
  logic                 cv;
  logic                 sw_now;
  logic [NW:0]          sd_round;
  logic [SPREAD_W-1:0]  sd_val;
  logic [PCT_W-1:0]     pct_mag, pct_val;
  logic [COUNT_W-1:0]   count_new;

  assign cv       = rv_q && refnz_q;
  assign sw_now   = cv && (neg_q != last_neg_q);
  assign sd_round = ((NW+1)'(div_quo) + 1'b1) >> 1;
  assign sd_val   = !sv_q ? '0 :
                    ((sd_round > (NW+1)'(SPREAD_MAX)) ? SPREAD_MAX : SPREAD_W'(sd_round));
  assign pct_mag  = (pct_q > NW'(PCT_LIMIT)) ? PCT_LIMIT : PCT_W'(pct_q);
  assign pct_val  = !cv ? '0 : (neg_q ? -pct_mag : pct_mag);
  assign count_new = (sw_now && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q       <= WL_RESET;
      wp_q       <= '0;
      held_q     <= '0;
      last_neg_q <= 1'b0;
      count_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        wl_q <= cfg_wdata_i;
      end
      if (cmd_i.accept) begin
        wp_q   <= (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + 1'b1;
        held_q <= held_new;
      end
      if (cmd_i.finish) begin
        count_q <= count_new;
        if (cv) begin
          last_neg_q <= neg_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q      <= $signed(sample_i);
      n_q      <= n_new;
      rv_q     <= 32'(held_new) > 32'(n_new);
      sv_q     <= 32'(held_new) >= 32'(n_new);
      rd_idx_q <= wp_prev;
      k_q      <= '0;
      s_q      <= '0;
      sq_q     <= '0;
      rsum_q   <= '0;
      ref_q    <= '0;
    end
    if (cmd_i.scan) begin
      rd_idx_q <= (rd_idx_q == '0) ? AW'(DEPTH - 1) : rd_idx_q - 1'b1;
      k_q      <= k_q + 1'b1;
      prev_q   <= cur;
      if (k_q != n_q) begin
        s_q  <= s_q + SW'(cur);
        sq_q <= sq_q + QW'(unsigned'(sqr));
      end
      if (k_q != '0 && !rise_d[SAMPLE_W] && rise_d != '0) begin
        rsum_q <= rsum_q + RSW'(rise_d[SAMPLE_W-1:0]);
      end
      if (k_q == n_q) begin
        ref_q <= cur;
      end
    end
    if (cmd_i.math1) begin
      ss_q    <= s_q * s_q;
      nsq_q   <= VW'(n_q) * VW'(sq_q);
      an_q    <= SCALED_W'(absdif) * SCALED_W'(PCT_SCALE);
      ad_q    <= absref;
      neg_q   <= (dif != '0) && (dif[SAMPLE_W] != ref_q[SAMPLE_W-1]);
      refnz_q <= (ref_q != '0);
    end
    if (cmd_i.div_pct) begin
      rise_q <= div_quo;
    end
    if (cmd_i.div_sd) begin
      pct_q <= div_quo;
    end
    if (cmd_i.finish) begin
      out_q <= OUT_TDATA_W'({count_new, sw_now, sd_val, sv_q, pct_val, cv,
                             (rv_q ? MEAN_W'(rise_q) : MEAN_W'(0)), rv_q});
    end
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

>>> hdl/windowed_trend_statistics.sv
`default_nettype none
// Sliding-window trend statistics over a stream of signed samples in hundredths.
// Each accepted word gives one result word: mean positive rise, percent change
// against the sample one window back, population standard deviation of the
// window, and a sign-switch flag with a saturating count. Samples sit in a
// ring RAM of MAX_WINDOW+1 entries, read one per cycle. An item runs a ring
// scan over the current sample and the n before it (n the window length), then
// the shared restoring divider (30 bits wide at the default) runs three times,
// one quotient bit a cycle, with the first run overlapped by the bit-serial
// square root. One item is in work at a time; the result register lets the
// next sample be taken while a result waits. The window length applies from
// the next accepted sample.
module windowed_trend_statistics #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [wdts_pkg::WL_W-1:0]             cfg_wdata_i,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // sample [20:0]
  input  wire logic [wdts_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // rise_valid [0], rise_mean [21:1], change_valid [22], change_percent [43:23],
  // spread_valid [44], spread [64:45], switch_now [65], switch_total [81:66]
  output logic      [wdts_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import wdts_pkg::*;

  wdts_cmd_t  cmd;
  wdts_stat_t stat;

  wdts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  wdts_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (s_axis_tdata[SAMPLE_W-1:0]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire
